[rtl/core/rbfi_pkg.sv]
// Shared types, constants and face geometry for the ray/box face intersector.
package rbfi_pkg;

    localparam int FRAC_BITS_DEF = 16;  // default fraction bits of the fixed-point format
    localparam int EPS_LOG2      = 20;  // determinant epsilon is 2^-EPS_LOG2
    localparam int NUM_FACES     = 6;
    localparam int COORD_W       = 32;
    localparam int DIST_W        = 32;
    localparam int NUM_W         = 33;  // |vertex - origin| along the normal
    localparam int DEN_W         = 32;  // |direction| along the normal
    localparam int REM_W         = 64;  // divider remainder
    localparam int ADDR_W        = 5;
    localparam int FACE_LAT      = 4;   // stages inside one face test

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_idx_t;

    // Per face: corner (0 lower, 1 upper), edge axes a and b, normal axis n.
    localparam int FACE_UPPER [NUM_FACES] = '{0, 0, 0, 1, 1, 1};
    localparam int FACE_A     [NUM_FACES] = '{0, 0, 1, 1, 0, 0};
    localparam int FACE_B     [NUM_FACES] = '{1, 2, 2, 2, 2, 1};
    localparam int FACE_N     [NUM_FACES] = '{2, 1, 0, 0, 1, 2};

    typedef struct packed {
        logic             hit;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } cand_t;

    typedef struct packed {
        logic             any;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } best_t;

    typedef struct packed {
        logic              any;
        logic              sat;
        logic [REM_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [DIST_W-1:0] quo;
    } div_t;

endpackage

[rtl/core/ray_box_face_intersect.sv]
// Top level: ray against axis-aligned box, nearest face hit, fully pipelined.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ------------------------------------
//  ray       in         ray_valid / ray_stall  origin_x/y/z, direction_x/y/z (Q16.16)
//  result    out        res_valid / res_stall  hit, distance (unsigned Q16.16)
//  config    in         APB psel/penable/...   box_min_x/y/z, box_max_x/y/z
//
//  One ray transaction per cycle while ray_stall is low. Stages: input register, 4 face
//  test stages, 6 nearest-hit cells of 2 stages each, 1 saturation stage, 32
//  divider cells (one quotient bit each) and the output register.
//  rst_n clears valid bits and the box registers; payload registers are not reset.
//  A stalled result parks the next finished transaction in a skid register;
//  ray_stall is high only while that skid register is full.
module ray_box_face_intersect #(
    parameter int FRAC_BITS = rbfi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // APB config
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbfi_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // ray channel
    input  logic                          ray_valid,
    output logic                          ray_stall,
    input  logic signed [31:0]            origin_x,
    input  logic signed [31:0]            origin_y,
    input  logic signed [31:0]            origin_z,
    input  logic signed [31:0]            direction_x,
    input  logic signed [31:0]            direction_y,
    input  logic signed [31:0]            direction_z,
    // result channel
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic                          hit,
    output logic [31:0]                   distance
);

    localparam int NF     = rbfi_pkg::NUM_FACES;
    localparam int DIST_W = rbfi_pkg::DIST_W;
    localparam int REM_W  = rbfi_pkg::REM_W;

    // ---------------- configuration registers ----------------
    logic signed [31:0] box_min_reg [3];
    logic signed [31:0] box_max_reg [3];
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                box_min_reg[k] <= '0;
                box_max_reg[k] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                rbfi_pkg::REG_MIN_X: box_min_reg[0] <= pwdata;
                rbfi_pkg::REG_MIN_Y: box_min_reg[1] <= pwdata;
                rbfi_pkg::REG_MIN_Z: box_min_reg[2] <= pwdata;
                rbfi_pkg::REG_MAX_X: box_max_reg[0] <= pwdata;
                rbfi_pkg::REG_MAX_Y: box_max_reg[1] <= pwdata;
                rbfi_pkg::REG_MAX_Z: box_max_reg[2] <= pwdata;
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            rbfi_pkg::REG_MIN_X: prdata = box_min_reg[0];
            rbfi_pkg::REG_MIN_Y: prdata = box_min_reg[1];
            rbfi_pkg::REG_MIN_Z: prdata = box_min_reg[2];
            rbfi_pkg::REG_MAX_X: prdata = box_max_reg[0];
            rbfi_pkg::REG_MAX_Y: prdata = box_max_reg[1];
            rbfi_pkg::REG_MAX_Z: prdata = box_max_reg[2];
            default:             prdata = '0;
        endcase
    end

    // ---------------- pipeline advance ----------------
    // Whole pipe moves together; it halts only while the skid register holds a result.
    logic skid_vld_reg;
    logic en;

    assign en        = !skid_vld_reg;
    assign ray_stall = skid_vld_reg;

    // input register
    logic               v0_reg;
    logic signed [31:0] o_reg [3];
    logic signed [31:0] d_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= ray_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg[0] <= origin_x;
            o_reg[1] <= origin_y;
            o_reg[2] <= origin_z;
            d_reg[0] <= direction_x;
            d_reg[1] <= direction_y;
            d_reg[2] <= direction_z;
        end
    end

    // ---------------- face test lanes ----------------
    rbfi_pkg::cand_t [NF-1:0]           cand_w;
    logic [rbfi_pkg::FACE_LAT-1:0]      fv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (en)
        begin
            fv_reg <= {fv_reg[rbfi_pkg::FACE_LAT-2:0], v0_reg};
        end
    end

    for (genvar f = 0; f < NF; f++)
    begin : g_face
        localparam int UP = rbfi_pkg::FACE_UPPER[f];
        localparam int AA = rbfi_pkg::FACE_A[f];
        localparam int AB = rbfi_pkg::FACE_B[f];
        localparam int AN = rbfi_pkg::FACE_N[f];

        rbfi_face #(
            .FRAC_BITS (FRAC_BITS)
        ) u_face (
            .clk  (clk),
            .en   (en),
            .o_a  (o_reg[AA]),
            .o_b  (o_reg[AB]),
            .o_n  (o_reg[AN]),
            .d_a  (d_reg[AA]),
            .d_b  (d_reg[AB]),
            .d_n  (d_reg[AN]),
            .vc_a ((UP != 0) ? box_max_reg[AA] : box_min_reg[AA]),
            .vc_b ((UP != 0) ? box_max_reg[AB] : box_min_reg[AB]),
            .vc_n ((UP != 0) ? box_max_reg[AN] : box_min_reg[AN]),
            .oc_a ((UP != 0) ? box_min_reg[AA] : box_max_reg[AA]),
            .oc_b ((UP != 0) ? box_min_reg[AB] : box_max_reg[AB]),
            .cand (cand_w[f])
        );
    end

    // ---------------- nearest-hit chain ----------------
    rbfi_pkg::best_t          best_w  [NF+1];
    rbfi_pkg::cand_t [NF-1:0] cands_w [NF];
    logic                     mvld_w  [NF+1];

    assign best_w[0]  = '0;
    assign cands_w[0] = cand_w;
    assign mvld_w[0]  = fv_reg[rbfi_pkg::FACE_LAT-1];

    for (genvar c = 0; c < NF; c++)
    begin : g_min
        if (c < NF - 1)
        begin : g_mid
            rbfi_min_cell #(
                .IDX (c)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_vld    (mvld_w[c]),
                .best_in   (best_w[c]),
                .cands_in  (cands_w[c]),
                .out_vld   (mvld_w[c+1]),
                .best_out  (best_w[c+1]),
                .cands_out (cands_w[c+1])
            );
        end
        else
        begin : g_last
            rbfi_min_cell #(
                .IDX (c)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_vld    (mvld_w[c]),
                .best_in   (best_w[c]),
                .cands_in  (cands_w[c]),
                .out_vld   (mvld_w[c+1]),
                .best_out  (best_w[c+1]),
                .cands_out ()
            );
        end
    end

    // ---------------- saturation check / divider load ----------------
    // distance = (num << FRAC_BITS) / den, saturating when the quotient needs 33+ bits
    rbfi_pkg::div_t     div_w [DIST_W+1];
    logic               dvld_w [DIST_W+1];
    logic               sv_reg;
    rbfi_pkg::div_t     sd_reg;
    logic [REM_W-1:0]   dividend;

    assign dividend = REM_W'(best_w[NF].num) << FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg <= mvld_w[NF];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sd_reg.any <= best_w[NF].any;
            sd_reg.sat <= {1'b0, dividend} >= {1'b0, best_w[NF].den, 32'd0};
            sd_reg.rem <= dividend;
            sd_reg.den <= best_w[NF].den;
            sd_reg.quo <= '0;
        end
    end

    assign div_w[0]  = sd_reg;
    assign dvld_w[0] = sv_reg;

    // quotient MSB first
    for (genvar i = 0; i < DIST_W; i++)
    begin : g_div
        rbfi_div_cell #(
            .BIT (DIST_W - 1 - i)
        ) u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .in_vld  (dvld_w[i]),
            .din     (div_w[i]),
            .out_vld (dvld_w[i+1]),
            .dout    (div_w[i+1])
        );
    end

    // ---------------- output register and skid ----------------
    logic               p_vld;
    logic               p_hit;
    logic [DIST_W-1:0]  p_dist;
    logic               res_valid_reg, hit_reg, skid_hit_reg, take_out;
    logic [DIST_W-1:0]  dist_reg, skid_dist_reg;

    assign p_vld  = dvld_w[DIST_W];
    assign p_hit  = div_w[DIST_W].any;
    assign p_dist = !div_w[DIST_W].any ? '0 :
                    (div_w[DIST_W].sat ? '1 : div_w[DIST_W].quo);

    assign take_out = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end
        else if (take_out)
        begin
            if (skid_vld_reg)
            begin
                res_valid_reg <= 1'b1;
                skid_vld_reg  <= 1'b0;
            end
            else
            begin
                res_valid_reg <= p_vld;
            end
        end
        else if (en && p_vld)
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_out)
        begin
            if (skid_vld_reg)
            begin
                hit_reg  <= skid_hit_reg;
                dist_reg <= skid_dist_reg;
            end
            else
            begin
                hit_reg  <= p_hit;
                dist_reg <= p_dist;
            end
        end
        else if (en && p_vld)
        begin
            skid_hit_reg  <= p_hit;
            skid_dist_reg <= p_dist;
        end
    end

    assign res_valid = res_valid_reg;
    assign hit       = hit_reg;
    assign distance  = dist_reg;

endmodule

[rtl/core/rbfi_face.sv]
// One face test lane: parallelogram hit test, four pipeline stages.
module rbfi_face #(
    parameter int FRAC_BITS = rbfi_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    o_a,
    input  logic signed [31:0]    o_b,
    input  logic signed [31:0]    o_n,
    input  logic signed [31:0]    d_a,
    input  logic signed [31:0]    d_b,
    input  logic signed [31:0]    d_n,
    input  logic signed [31:0]    vc_a,
    input  logic signed [31:0]    vc_b,
    input  logic signed [31:0]    vc_n,
    input  logic signed [31:0]    oc_a,
    input  logic signed [31:0]    oc_b,
    output rbfi_pkg::cand_t       cand
);

    localparam int S  = 3 * FRAC_BITS - rbfi_pkg::EPS_LOG2;
    localparam int PW = S + 1;
    localparam int HL = (PW + 1) / 2;
    localparam int HH = PW - HL;
    localparam int CW = (PW > 32) ? PW : 32;

    // config-derived edges
    logic signed [32:0] e1, e2;
    logic               e1_neg_reg, e2_neg_reg;
    logic [32:0]        e1_mag_reg, e2_mag_reg;
    logic [65:0]        pe_reg;
    logic [PW-1:0]      psat_reg;
    logic [65:0]        plim;

    assign e1   = 33'(oc_a) - 33'(vc_a);
    assign e2   = 33'(oc_b) - 33'(vc_b);
    assign plim = 66'(1) << S;

    always_ff @(posedge clk)
    begin
        e1_neg_reg <= e1[32];
        e2_neg_reg <= e2[32];
        e1_mag_reg <= e1[32] ? 33'(-e1) : 33'(e1);
        e2_mag_reg <= e2[32] ? 33'(-e2) : 33'(e2);
        pe_reg     <= 66'(e1_mag_reg) * 66'(e2_mag_reg);
        psat_reg   <= (pe_reg >= plim) ? plim[PW-1:0] : pe_reg[PW-1:0];
    end

    // stage 1: offsets
    logic signed [32:0] off_a_reg, off_b_reg, num_reg;
    logic signed [31:0] da_reg, db_reg, dn_reg;
    logic [31:0]        dm_reg;

    // stage 2: products
    logic signed [64:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic [64:0]        g1_reg, g2_reg;
    logic               g1neg_reg, g2neg_reg, tok_reg;
    logic [PW-1:0]      dmsat_reg;
    logic [32:0]        num_mag2_reg;
    logic [31:0]        dm2_reg;
    logic [CW-1:0]      dm_ext, dlim;

    assign dm_ext = CW'(dm_reg);
    assign dlim   = CW'(1) << S;

    // stage 3: sums and determinant partials
    logic signed [65:0] sum1_reg, sum2_reg;
    logic [64:0]        g1_3_reg, g2_3_reg;
    logic               g1neg3_reg, g2neg3_reg, tok3_reg;
    logic [2*HL-1:0]    ll_reg;
    logic [PW-1:0]      lh_reg, hl_reg;
    logic [2*HH-1:0]    hh_reg;
    logic [32:0]        num_mag3_reg;
    logic [31:0]        dm3_reg;

    // stage 4: decision
    rbfi_pkg::cand_t    cand_reg;
    logic [2*PW-1:0]    det_sum;
    logic               det_ok, u_ok, v_ok;

    function automatic logic in_unit(input logic signed [65:0] s,
                                     input logic [64:0] g, input logic neg);
        logic signed [66:0] se;
        logic signed [66:0] ge;
        se = 67'(s);
        ge = $signed({2'b00, g});
        return neg ? (se <= 0 && se + ge >= 0) : (se >= 0 && se <= ge);
    endfunction

    assign det_sum = (2*PW)'(ll_reg)
                   + (((2*PW)'(lh_reg) + (2*PW)'(hl_reg)) << HL)
                   + ((2*PW)'(hh_reg) << (2*HL));
    assign det_ok  = |det_sum[2*PW-1:S];
    assign u_ok    = in_unit(sum1_reg, g1_3_reg, g1neg3_reg);
    assign v_ok    = in_unit(sum2_reg, g2_3_reg, g2neg3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            off_a_reg <= 33'(o_a) - 33'(vc_a);
            off_b_reg <= 33'(o_b) - 33'(vc_b);
            num_reg   <= 33'(vc_n) - 33'(o_n);
            da_reg    <= d_a;
            db_reg    <= d_b;
            dn_reg    <= d_n;
            dm_reg    <= d_n[31] ? 32'(-d_n) : 32'(d_n);

            a1_reg       <= 65'(off_a_reg) * 65'(dn_reg);
            b1_reg       <= 65'(num_reg) * 65'(da_reg);
            a2_reg       <= 65'(off_b_reg) * 65'(dn_reg);
            b2_reg       <= 65'(num_reg) * 65'(db_reg);
            g1_reg       <= 65'(e1_mag_reg) * 65'(dm_reg);
            g2_reg       <= 65'(e2_mag_reg) * 65'(dm_reg);
            g1neg_reg    <= e1_neg_reg ^ dn_reg[31];
            g2neg_reg    <= e2_neg_reg ^ dn_reg[31];
            tok_reg      <= (num_reg != 33'sd0) && (num_reg[32] == dn_reg[31]);
            dmsat_reg    <= (dm_ext >= dlim) ? dlim[PW-1:0] : dm_ext[PW-1:0];
            num_mag2_reg <= num_reg[32] ? 33'(-num_reg) : 33'(num_reg);
            dm2_reg      <= dm_reg;

            sum1_reg     <= 66'(a1_reg) + 66'(b1_reg);
            sum2_reg     <= 66'(a2_reg) + 66'(b2_reg);
            g1_3_reg     <= g1_reg;
            g2_3_reg     <= g2_reg;
            g1neg3_reg   <= g1neg_reg;
            g2neg3_reg   <= g2neg_reg;
            tok3_reg     <= tok_reg;
            ll_reg       <= (2*HL)'(psat_reg[HL-1:0]) * (2*HL)'(dmsat_reg[HL-1:0]);
            lh_reg       <= PW'(psat_reg[HL-1:0]) * PW'(dmsat_reg[PW-1:HL]);
            hl_reg       <= PW'(psat_reg[PW-1:HL]) * PW'(dmsat_reg[HL-1:0]);
            hh_reg       <= (2*HH)'(psat_reg[PW-1:HL]) * (2*HH)'(dmsat_reg[PW-1:HL]);
            num_mag3_reg <= num_mag2_reg;
            dm3_reg      <= dm2_reg;

            cand_reg.hit <= det_ok & u_ok & v_ok & tok3_reg;
            cand_reg.num <= num_mag3_reg;
            cand_reg.den <= dm3_reg;
        end
    end

    assign cand = cand_reg;

endmodule

[rtl/core/rbfi_min_cell.sv]
// Nearest-hit cell: folds one face candidate into the running best, two stages.
module rbfi_min_cell #(
    parameter int IDX = 0
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       en,
    input  logic                                       in_vld,
    input  rbfi_pkg::best_t                            best_in,
    input  rbfi_pkg::cand_t [rbfi_pkg::NUM_FACES-1:0]  cands_in,
    output logic                                       out_vld,
    output rbfi_pkg::best_t                            best_out,
    output rbfi_pkg::cand_t [rbfi_pkg::NUM_FACES-1:0]  cands_out
);

    logic                                      vld_a_reg, vld_b_reg;
    rbfi_pkg::best_t                           best_a_reg, best_b_reg, best_next;
    rbfi_pkg::cand_t [rbfi_pkg::NUM_FACES-1:0] cands_a_reg, cands_b_reg;
    logic [64:0]                               pc_reg, pb_reg;
    logic                                      take;

    // cross-multiplied compare of num/den fractions
    assign take = cands_a_reg[IDX].hit && (!best_a_reg.any || pc_reg < pb_reg);

    always_comb
    begin
        best_next = best_a_reg;
        if (take)
        begin
            best_next.any = 1'b1;
            best_next.num = cands_a_reg[IDX].num;
            best_next.den = cands_a_reg[IDX].den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_vld;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_a_reg  <= best_in;
            cands_a_reg <= cands_in;
            pc_reg      <= 65'(cands_in[IDX].num) * 65'(best_in.den);
            pb_reg      <= 65'(best_in.num) * 65'(cands_in[IDX].den);
            best_b_reg  <= best_next;
            cands_b_reg <= cands_a_reg;
        end
    end

    assign out_vld   = vld_b_reg;
    assign best_out  = best_b_reg;
    assign cands_out = cands_b_reg;

endmodule

[rtl/core/rbfi_div_cell.sv]
// Divider cell: one restoring quotient bit per stage.
module rbfi_div_cell #(
    parameter int BIT = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  rbfi_pkg::div_t din,
    output logic           out_vld,
    output rbfi_pkg::div_t dout
);

    logic                          vld_reg;
    rbfi_pkg::div_t                d_reg, d_next;
    logic [rbfi_pkg::REM_W-1:0]    sub;

    assign sub = rbfi_pkg::REM_W'(din.den) << BIT;

    always_comb
    begin
        d_next = din;
        if (din.rem >= sub)
        begin
            d_next.rem      = din.rem - sub;
            d_next.quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_vld = vld_reg;
    assign dout    = d_reg;

endmodule
